// ===== hdl/acld_pkg.sv =====
// shared types, command patterns and character codes for the command line decoder
package acld_pkg;

  localparam int unsigned PAT_COUNT = 11;
  localparam int unsigned PAT_MAX   = 11;
  localparam int unsigned ARG_W     = 32;

  typedef enum logic [1:0] {
    OUT_OK       = 2'd0,
    OUT_BAD_ARG  = 2'd1,
    OUT_UNKNOWN  = 2'd2,
    OUT_TOO_LONG = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    CMD_HELP       = 4'd0,
    CMD_PING       = 4'd1,
    CMD_ID         = 4'd2,
    CMD_TEMP       = 4'd3,
    CMD_ZERO       = 4'd4,
    CMD_R42        = 4'd5,
    CMD_TC_QUERY   = 4'd6,
    CMD_TC_STOP    = 4'd7,
    CMD_TC_CURRENT = 4'd8,
    CMD_TC_TEMP    = 4'd9
  } command_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2
  } arg_phase_e;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // patterns padded on the right, first character in the top byte
  localparam logic [8*PAT_MAX-1:0] PAT_TEXT [PAT_COUNT] = '{
    "HELP       ", "?          ", "PING       ", "ID?        ", "TEMP?      ",
    "ZERO       ", "R42?       ", "TC?        ", "TC STOP    ", "TC CURRENT ",
    "TC TEMP    "
  };

  localparam logic [3:0] PAT_LEN [PAT_COUNT] = '{
    4'd4, 4'd1, 4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd3, 4'd7, 4'd11, 4'd8
  };

  localparam command_e PAT_CODE [PAT_COUNT] = '{
    CMD_HELP, CMD_HELP, CMD_PING, CMD_ID, CMD_TEMP, CMD_ZERO, CMD_R42,
    CMD_TC_QUERY, CMD_TC_STOP, CMD_TC_CURRENT, CMD_TC_TEMP
  };

  // number of exact-match patterns and the index of the first argument prefix
  localparam int unsigned EXACT_COUNT = 9;

  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] data;
  } arg_ctrl_t;

  typedef struct packed {
    logic             ok;
    logic [ARG_W-1:0] value;
  } arg_stat_t;

  function automatic logic [7:0] pat_char(logic [8*PAT_MAX-1:0] text, logic [3:0] pos);
    logic [8*PAT_MAX-1:0] shifted;
    shifted = text << {pos, 3'b000};
    return shifted[8*PAT_MAX-1 -: 8];
  endfunction

endpackage

// ===== hdl/acld_arg.sv =====
// signed decimal argument parser with wrapping accumulate
module acld_arg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acld_pkg::arg_ctrl_t ctrl_i,
  output acld_pkg::arg_stat_t stat_o
);
  import acld_pkg::*;

  arg_phase_e       phase_q, phase_d;
  logic [ARG_W-1:0] accum_q, accum_d;
  logic             neg_q, neg_d;
  logic             seen_q, seen_d;
  logic             invalid_q, invalid_d;

  logic             digit;
  logic [ARG_W-1:0] times_ten;

  assign digit     = (ctrl_i.data >= CHAR_ZERO) && (ctrl_i.data <= CHAR_NINE);
  // ascii digits carry their value in the low nibble
  assign times_ten = (accum_q << 3) + (accum_q << 1) + {{(ARG_W-4){1'b0}}, ctrl_i.data[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      accum_q   <= '0;
      neg_q     <= 1'b0;
      seen_q    <= 1'b0;
      invalid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      accum_q   <= accum_d;
      neg_q     <= neg_d;
      seen_q    <= seen_d;
      invalid_q <= invalid_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    invalid_d = invalid_q;
    if (ctrl_i.clear) begin
      phase_d   = PH_LEAD;
      accum_d   = '0;
      neg_d     = 1'b0;
      seen_d    = 1'b0;
      invalid_d = 1'b0;
    end else if (ctrl_i.feed && !invalid_q) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (ctrl_i.data == CHAR_SPACE) begin
            phase_d = PH_LEAD;
          end else if (ctrl_i.data == CHAR_MINUS) begin
            neg_d   = 1'b1;
            phase_d = PH_DIGITS;
          end else if (ctrl_i.data == CHAR_PLUS) begin
            phase_d = PH_DIGITS;
          end else if (digit) begin
            accum_d = times_ten;
            seen_d  = 1'b1;
            phase_d = PH_DIGITS;
          end else begin
            invalid_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            accum_d = times_ten;
            seen_d  = 1'b1;
          end else if (ctrl_i.data == CHAR_SPACE) begin
            phase_d = PH_TRAIL;
          end else begin
            invalid_d = 1'b1;
          end
        end
        default: begin
          if (ctrl_i.data != CHAR_SPACE) begin
            invalid_d = 1'b1;
          end
        end
      endcase
    end
  end

  assign stat_o.ok    = seen_q && !invalid_q;
  assign stat_o.value = neg_q ? (~accum_q + {{(ARG_W-1){1'b0}}, 1'b1}) : accum_q;

endmodule

// ===== hdl/ascii_command_line_decoder_core.sv =====
// ascii command line decoder: line assembly, command matching and result register
// a line's last byte is registered in the input register on accept, and its result is
// registered in the result register when that byte is processed
// throughput: one byte per cycle absent output stalls; single-pass match, multiply-by-ten
// reset: all line state clears at once, no clearing pass; both word registers empty
module ascii_command_line_decoder_core #(
  parameter int unsigned MAX_LINE = 96
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  outcome_o,
  output logic [3:0]                  command_o,
  output logic signed [acld_pkg::ARG_W-1:0] argument_o
);
  import acld_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LINE);
  localparam logic [CntW-1:0] MaxHeld = CntW'(MAX_LINE - 1);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       proc;

  // line state
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      text_len_q, text_len_d;
  logic [PAT_COUNT-1:0] mask_q, mask_d;
  logic                 ended_q, ended_d;

  // result register
  logic             out_valid_q;
  outcome_e         outcome_q, outcome_d;
  command_e         command_q, command_d;
  logic [ARG_W-1:0] arg_q, arg_d;
  logic             res_valid;

  arg_ctrl_t arg_ctrl;
  arg_stat_t arg_stat;

  logic            is_eol;
  logic            at_limit;
  logic [7:0]      pos8;
  logic [7:0]      len8;
  logic            feed_hit;
  logic            found;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      text_len_q <= '0;
      mask_q     <= '1;
      ended_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        count_q    <= count_d;
        text_len_q <= text_len_d;
        mask_q     <= mask_d;
        ended_q    <= ended_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      outcome_q <= outcome_d;
      command_q <= command_d;
      arg_q     <= arg_d;
    end
  end

  assign is_eol   = (byte_q == CHAR_CR) || (byte_q == CHAR_LF);
  assign at_limit = count_q >= MaxHeld;
  assign pos8     = {{(8-CntW){1'b0}}, count_q};
  assign len8     = {{(8-CntW){1'b0}}, text_len_q};

  always_comb begin
    count_d    = count_q;
    text_len_d = text_len_q;
    mask_d     = mask_q;
    ended_d    = ended_q;
    res_valid  = 1'b0;
    outcome_d  = OUT_UNKNOWN;
    command_d  = CMD_HELP;
    arg_d      = '0;
    feed_hit   = 1'b0;
    found      = 1'b0;
    arg_ctrl.clear = 1'b0;
    arg_ctrl.feed  = 1'b0;
    arg_ctrl.data  = byte_q;

    if (is_eol) begin
      if (count_q != '0) begin
        // end of line: exact commands first, then argument prefixes
        count_d    = '0;
        text_len_d = '0;
        mask_d     = '1;
        ended_d    = 1'b0;
        arg_ctrl.clear = 1'b1;
        if (text_len_q != '0) begin
          res_valid = 1'b1;
          for (int unsigned i = 0; i < EXACT_COUNT; i++) begin
            if (!found && mask_q[i] && (len8 == {4'b0000, PAT_LEN[i]})) begin
              found     = 1'b1;
              outcome_d = OUT_OK;
              command_d = PAT_CODE[i];
            end
          end
          for (int unsigned i = EXACT_COUNT; i < PAT_COUNT; i++) begin
            if (!found && mask_q[i] && (len8 >= {4'b0000, PAT_LEN[i]})) begin
              found     = 1'b1;
              command_d = PAT_CODE[i];
              if (arg_stat.ok) begin
                outcome_d = OUT_OK;
                arg_d     = arg_stat.value;
              end else begin
                outcome_d = OUT_BAD_ARG;
              end
            end
          end
        end
      end
    end else if (at_limit) begin
      count_d    = '0;
      text_len_d = '0;
      mask_d     = '1;
      ended_d    = 1'b0;
      arg_ctrl.clear = 1'b1;
      res_valid  = 1'b1;
      outcome_d  = OUT_TOO_LONG;
    end else begin
      count_d = count_q + 1'b1;
      if (!ended_q) begin
        if (byte_q == CHAR_NUL) begin
          ended_d = 1'b1;
        end else begin
          text_len_d = count_q + 1'b1;
          for (int unsigned i = 0; i < PAT_COUNT; i++) begin
            if (pos8 < {4'b0000, PAT_LEN[i]}) begin
              if (pat_char(PAT_TEXT[i], pos8[3:0]) != byte_q) begin
                mask_d[i] = 1'b0;
              end
            end else if (i >= EXACT_COUNT && mask_q[i]) begin
              feed_hit = 1'b1;
            end
          end
          arg_ctrl.feed = feed_hit;
        end
      end
    end

    // only act on the parser when a word is really taken
    arg_ctrl.clear = arg_ctrl.clear && proc;
    arg_ctrl.feed  = arg_ctrl.feed && proc;
  end

  acld_arg u_arg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (arg_ctrl),
    .stat_o (arg_stat)
  );

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign command_o   = command_q;
  assign argument_o  = arg_q;

endmodule
